[sv/gbs_pkg.sv]
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int IDX_W       = 10;
    localparam int IN_COORD_W  = 16;
    localparam int MAX_COORD_W = 24;
    localparam int THR_W       = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // register index taken from paddr[2]
    localparam logic REG_IOU_THRESHOLD = 1'b0;

    localparam logic [THR_W-1:0] IOU_THRESHOLD_RESET = 16'd19661;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

[sv/greedy_box_suppression.sv]
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy IoU non-maximum suppression over a store of kept boxes.
//
//   channel  | handshake                         | payload
//   ---------+-----------------------------------+------------------------------
//   command  | start, busy                       | i_box_index, i_left_x,
//            |                                   | i_top_y, i_right_x,
//            |                                   | i_bottom_y, i_last_candidate
//   result   | o_strobe (one cycle)              | o_result_index, o_kept,
//            |                                   | o_store_overflow, o_result_last
//   config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
// A word passes from accept to result strobe through the candidate area step,
// one memory read per stored box, the drain of the six-stage compare pipeline
// and a step that settles the decision. The single compare pipeline (overlap,
// one shared multiplier, split threshold product) does this per-box work.
// Synchronous active-low reset empties the store and loads the threshold 0.3.
// The receiver cannot stall; busy is low again in the cycle of the strobe.
// ----------------------------------------------------------------------------
module greedy_box_suppression
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT   = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   start,
    output logic                   busy,
    input  logic [IDX_W-1:0]       i_box_index,
    input  logic [IN_COORD_W-1:0]  i_left_x,
    input  logic [IN_COORD_W-1:0]  i_top_y,
    input  logic [IN_COORD_W-1:0]  i_right_x,
    input  logic [IN_COORD_W-1:0]  i_bottom_y,
    input  logic                   i_last_candidate,

    output logic                   o_strobe,
    output logic [IDX_W-1:0]       o_result_index,
    output logic                   o_kept,
    output logic                   o_store_overflow,
    output logic                   o_result_last,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int CW    = COORD_BITS;
    localparam int AREA_W = 2 * CW;
    localparam int UNI_W = AREA_W + 1;
    localparam int UL_W  = UNI_W / 2;
    localparam int UH_W  = UNI_W - UL_W;
    localparam int RHS_W = THR_W + UNI_W;
    localparam int ENT_W = 4 * CW + AREA_W;
    localparam int AW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W = $clog2(MAX_KEPT + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT);

    // ---------------- configuration ----------------
    logic [THR_W-1:0] r_thr;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_IOU_THRESHOLD);
    assign prdata = (paddr[2] == REG_IOU_THRESHOLD) ? APB_DATA_W'(r_thr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= IOU_THRESHOLD_RESET;
        end else if (cfg_wr) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    // ---------------- control ----------------
    t_state r_state, n_state;

    logic             accept;
    logic             issue;
    logic             use_area;
    logic             finish;
    logic             pipe_empty;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rd_ptr;
    logic [5:0]       r_pvld;
    logic             r_any_hit;
    logic             hit6;

    logic [IDX_W-1:0] r_idx;
    logic             r_last;
    logic [CW-1:0]    r_cx0, r_cy0, r_cx1, r_cy1;
    logic [AREA_W-1:0] r_area_a;

    logic [MAX_COORD_W-1:0] ext_x0, ext_y0, ext_x1, ext_y1;
    logic [CW-1:0]          in_x0, in_y0, in_x1, in_y1;

    assign accept     = start & ~busy;
    assign pipe_empty = (r_pvld == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept) n_state = ST_AREA;
            ST_AREA:  n_state = ST_SCAN;
            ST_SCAN:  if (r_rd_ptr == r_count) n_state = ST_DRAIN;
            ST_DRAIN: if (pipe_empty) n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy     = 1'b1;
        issue    = 1'b0;
        use_area = 1'b0;
        finish   = 1'b0;
        unique case (r_state)
            ST_IDLE:  busy = 1'b0;
            ST_AREA:  use_area = 1'b1;
            ST_SCAN:  issue = (r_rd_ptr != r_count);
            ST_DRAIN: ;
            ST_DONE:  finish = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // candidate intake: low COORD_BITS of each edge, inverted edges clamped
    assign ext_x0 = MAX_COORD_W'(i_left_x);
    assign ext_y0 = MAX_COORD_W'(i_top_y);
    assign ext_x1 = MAX_COORD_W'(i_right_x);
    assign ext_y1 = MAX_COORD_W'(i_bottom_y);
    assign in_x0  = ext_x0[CW-1:0];
    assign in_y0  = ext_y0[CW-1:0];
    assign in_x1  = (ext_x1[CW-1:0] < in_x0) ? in_x0 : ext_x1[CW-1:0];
    assign in_y1  = (ext_y1[CW-1:0] < in_y0) ? in_y0 : ext_y1[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx  <= i_box_index;
            r_last <= i_last_candidate;
            r_cx0  <= in_x0;
            r_cy0  <= in_y0;
            r_cx1  <= in_x1;
            r_cy1  <= in_y1;
        end
    end

    // ---------------- store ----------------
    logic [ENT_W-1:0] mem [MAX_KEPT];
    logic [ENT_W-1:0] r_rd_data;
    logic             store_en;
    logic             keep;
    logic             full;

    assign keep     = ~r_any_hit;
    assign full     = (r_count >= CNT_MAX);
    assign store_en = finish & keep & ~full;

    always_ff @(posedge i_clk) begin
        if (store_en) begin
            mem[r_count[AW-1:0]] <= {r_cx0, r_cy0, r_cx1, r_cy1, r_area_a};
        end
        if (issue) begin
            r_rd_data <= mem[r_rd_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (accept) begin
                r_rd_ptr <= '0;
            end else if (issue) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (finish) begin
                if (r_last) begin
                    r_count <= '0;
                end else if (store_en) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // ---------------- compare pipeline ----------------
    logic [CW-1:0]     s1_x0, s1_y0, s1_x1, s1_y1;
    logic [AREA_W-1:0] s1_area;
    logic [CW-1:0]     ov_xlo, ov_xhi, ov_ylo, ov_yhi;
    logic [CW-1:0]     r_w2, r_h2;
    logic [AREA_W-1:0] r_area2;
    logic [CW-1:0]     mul_a, mul_b;
    logic [AREA_W-1:0] mul_p;
    logic [AREA_W-1:0] r_ov3, r_area3;
    logic [AREA_W-1:0] r_ov4;
    logic [UNI_W-1:0]  r_uni4;
    logic [AREA_W-1:0] r_ov5;
    logic              r_zero5;
    logic [THR_W+UL_W-1:0] r_plo5;
    logic [THR_W+UH_W-1:0] r_phi5;
    logic [AREA_W-1:0] r_ov6;
    logic              r_zero6;
    logic [RHS_W-1:0]  r_rhs6;
    logic [RHS_W-1:0]  lhs6;

    assign {s1_x0, s1_y0, s1_x1, s1_y1, s1_area} = r_rd_data;

    assign ov_xlo = (r_cx0 > s1_x0) ? r_cx0 : s1_x0;
    assign ov_xhi = (r_cx1 < s1_x1) ? r_cx1 : s1_x1;
    assign ov_ylo = (r_cy0 > s1_y0) ? r_cy0 : s1_y0;
    assign ov_yhi = (r_cy1 < s1_y1) ? r_cy1 : s1_y1;

    // shared multiplier: candidate area once, then one overlap per entry
    assign mul_a = use_area ? (r_cx1 - r_cx0) : r_w2;
    assign mul_b = use_area ? (r_cy1 - r_cy0) : r_h2;
    assign mul_p = AREA_W'(mul_a) * AREA_W'(mul_b);

    assign lhs6 = RHS_W'({r_ov6, 16'd0});
    assign hit6 = r_pvld[5] & (r_zero6 ? (r_thr == '0) : (lhs6 >= r_rhs6));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld    <= '0;
            r_any_hit <= 1'b0;
        end else begin
            r_pvld <= {r_pvld[4:0], issue};
            if (accept) begin
                r_any_hit <= 1'b0;
            end else if (hit6) begin
                r_any_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (use_area) begin
            r_area_a <= mul_p;
        end
        r_w2    <= (ov_xhi > ov_xlo) ? (ov_xhi - ov_xlo) : '0;
        r_h2    <= (ov_yhi > ov_ylo) ? (ov_yhi - ov_ylo) : '0;
        r_area2 <= s1_area;
        r_ov3   <= mul_p;
        r_area3 <= r_area2;
        r_ov4   <= r_ov3;
        r_uni4  <= UNI_W'(r_area_a) + UNI_W'(r_area3) - UNI_W'(r_ov3);
        r_ov5   <= r_ov4;
        r_zero5 <= (r_uni4 == '0);
        r_plo5  <= (THR_W+UL_W)'(r_thr) * (THR_W+UL_W)'(r_uni4[UL_W-1:0]);
        r_phi5  <= (THR_W+UH_W)'(r_thr) * (THR_W+UH_W)'(r_uni4[UNI_W-1:UL_W]);
        r_ov6   <= r_ov5;
        r_zero6 <= r_zero5;
        r_rhs6  <= RHS_W'(r_plo5) + (RHS_W'(r_phi5) << UL_W);
    end

    // ---------------- result ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            o_result_index   <= r_idx;
            o_kept           <= keep;
            o_store_overflow <= keep & full;
            o_result_last    <= r_last;
        end
    end

endmodule
